FILE: hdl/bmp24_pkg.sv
// shared types, constants and byte helpers for the bmp stream encoder
`timescale 1ns / 1ps

package bmp24_pkg;

    localparam int COORD_BITS  = 16;
    localparam int CFG_W       = 16;
    // compare width: wide enough that counter + 1 never wraps
    localparam int CMP_W       = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int POS_W       = 6;
    localparam int SIZE_W      = 32;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [7:0] MAGIC_B       = 8'h42;
    localparam logic [7:0] MAGIC_M       = 8'h4D;
    localparam logic [7:0] PIXEL_OFFSET  = 8'd54;
    localparam logic [7:0] INFO_HDR_SIZE = 8'd40;
    localparam logic [7:0] BITS_PER_PIX  = 8'd24;
    localparam logic [7:0] PLANES        = 8'd1;

    // byte positions within one entry's burst
    localparam logic [POS_W-1:0] POS_BLUE  = 6'd54;
    localparam logic [POS_W-1:0] POS_GREEN = 6'd55;
    localparam logic [POS_W-1:0] POS_RED   = 6'd56;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } img_cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       hdr;
        logic       img_end;
        logic [1:0] pad;
    } pix_entry_t;

    // (q * 255) >> 15 with saturation above 1.0
    function automatic logic [7:0] to_byte(input logic [15:0] q);
        logic [23:0] prod;
        prod = {q, 8'h00} - {8'h00, q};
        to_byte = prod[23] ? 8'hFF : prod[22:15];
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [POS_W-1:0] pos,
                                            input img_cfg_t cfg,
                                            input logic [SIZE_W-1:0] size);
        logic [7:0] b;
        b = 8'h00;
        case (pos)
            6'd0:    b = MAGIC_B;
            6'd1:    b = MAGIC_M;
            6'd2:    b = size[7:0];
            6'd3:    b = size[15:8];
            6'd4:    b = size[23:16];
            6'd5:    b = size[31:24];
            6'd10:   b = PIXEL_OFFSET;
            6'd14:   b = INFO_HDR_SIZE;
            6'd18:   b = cfg.width[7:0];
            6'd19:   b = cfg.width[15:8];
            6'd22:   b = cfg.height[7:0];
            6'd23:   b = cfg.height[15:8];
            6'd26:   b = PLANES;
            6'd28:   b = BITS_PER_PIX;
            default: b = 8'h00;
        endcase
        hdr_byte = b;
    endfunction

endpackage

FILE: hdl/bmp24_stream_encoder.sv
// top level: config registers, front end, pixel queue and byte sequencer
// after a pixel transfer, its first byte passes a queue slot and then the output byte register
// a pixel costs 3 bytes plus (width mod 4) pad bytes at a row end, plus 54 header
// bytes for the first pixel of an image; the back sequencer sends one byte a cycle
// while pixels are queued and bytes are popped; new pixels can queue up meanwhile
// reset: width and height 1, row and column counters zero, queue and output empty
`timescale 1ns / 1ps

module bmp24_stream_encoder
    import bmp24_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  out_byte,
    output logic        last_of_pixel,
    output logic        end_of_image
);

    img_cfg_t   cfg_reg, cfg_next;
    logic       q_wr;
    logic       q_pop;
    logic       q_full;
    logic       q_empty;
    pix_entry_t q_wdata;
    pix_entry_t q_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_WIDTH:  cfg_next.width  = cfg_data;
                REG_HEIGHT: cfg_next.height = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= CFG_W'(1);
            cfg_reg.height <= CFG_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = q_full;

    bmp24_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .push   (push),
        .red    (red),
        .green  (green),
        .blue   (blue),
        .q_full (q_full),
        .q_wr   (q_wr),
        .q_data (q_wdata)
    );

    bmp24_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    bmp24_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .out_byte      (out_byte),
        .last_of_pixel (last_of_pixel),
        .end_of_image  (end_of_image),
        .empty         (empty),
        .pop           (pop)
    );

endmodule

FILE: hdl/bmp24_front.sv
// front end: takes pixels, converts channels and tracks row and image position
`timescale 1ns / 1ps

module bmp24_front
    import bmp24_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  img_cfg_t   cfg,
    input  logic       push,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    input  logic       q_full,
    output logic       q_wr,
    output pix_entry_t q_data
);

    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic                  row_end;
    logic                  img_end;

    assign q_wr = push && !q_full;

    always_comb
    begin
        row_end = (CMP_W'(col_reg) + CMP_W'(1)) >= CMP_W'(cfg.width);
        img_end = row_end && ((CMP_W'(row_reg) + CMP_W'(1)) >= CMP_W'(cfg.height));

        q_data.blue    = to_byte(blue);
        q_data.green   = to_byte(green);
        q_data.red     = to_byte(red);
        q_data.hdr     = (col_reg == '0) && (row_reg == '0);
        q_data.img_end = img_end;
        q_data.pad     = row_end ? cfg.width[1:0] : 2'b00;

        col_next = col_reg;
        row_next = row_reg;
        if (q_wr)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = img_end ? '0 : row_reg + COORD_BITS'(1);
            end
            else
            begin
                col_next = col_reg + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

FILE: hdl/bmp24_queue.sv
// short queue of classified pixels between front and back
`timescale 1ns / 1ps

module bmp24_queue
    import bmp24_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  pix_entry_t wr_data,
    input  logic       rd_en,
    output pix_entry_t rd_data,
    output logic       full,
    output logic       empty
);

    pix_entry_t          slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + (QPTR_W+1)'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - (QPTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && full |-> rd_en)
        else $error("queue written while full");

endmodule

FILE: hdl/bmp24_back.sv
// back end: byte sequencer for header, pixel bytes and row padding
`timescale 1ns / 1ps

module bmp24_back
    import bmp24_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  img_cfg_t   cfg,
    input  logic       q_empty,
    input  pix_entry_t q_head,
    output logic       q_pop,
    output logic [7:0] out_byte,
    output logic       last_of_pixel,
    output logic       end_of_image,
    output logic       empty,
    input  logic       pop
);

    logic [SIZE_W-1:0] prod_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [17:0]       pad_rows;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              started_reg, started_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg;
    logic              lop_reg;
    logic              eoi_reg;

    logic [POS_W-1:0]  pos_eff;
    logic [POS_W-1:0]  last_pos;
    logic              is_last;
    logic              advance;
    logic              take;
    logic [7:0]        byte_sel;

    // file size follows the config registers, registered through prod_reg and then size_reg
    assign pad_rows = 18'(cfg.width[1:0]) * 18'(cfg.height);

    always_ff @(posedge clk)
    begin
        prod_reg <= SIZE_W'(cfg.width) * SIZE_W'(cfg.height);
        size_reg <= SIZE_W'(PIXEL_OFFSET) + (prod_reg << 1) + prod_reg
                    + SIZE_W'(pad_rows);
    end

    always_comb
    begin
        pos_eff  = started_reg ? pos_reg : (q_head.hdr ? '0 : POS_BLUE);
        last_pos = POS_RED + POS_W'(q_head.pad);
        is_last  = (pos_eff == last_pos);
        take     = pop && out_valid_reg;
        advance  = !q_empty && (!out_valid_reg || take);
        q_pop    = advance && is_last;

        if (pos_eff < POS_BLUE)
            byte_sel = hdr_byte(pos_eff, cfg, size_reg);
        else if (pos_eff == POS_BLUE)
            byte_sel = q_head.blue;
        else if (pos_eff == POS_GREEN)
            byte_sel = q_head.green;
        else if (pos_eff == POS_RED)
            byte_sel = q_head.red;
        else
            byte_sel = 8'h00;

        out_valid_next = advance ? 1'b1 : (take ? 1'b0 : out_valid_reg);
        started_next   = advance ? !is_last : started_reg;
        pos_next       = advance ? pos_eff + POS_W'(1) : pos_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_byte_reg <= byte_sel;
            lop_reg      <= is_last;
            eoi_reg      <= is_last && q_head.img_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_byte      = out_byte_reg;
    assign last_of_pixel = lop_reg;
    assign end_of_image  = eoi_reg;
    assign empty         = !out_valid_reg;

    a_eoi_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && eoi_reg |-> lop_reg)
        else $error("end of image without end of pixel");

    a_entry_held: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> !q_empty)
        else $error("queue entry lost part way through its bytes");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> pos_eff <= last_pos)
        else $error("byte position ran past the end of the entry");

endmodule
